### hdl/delimiter_stream_splitter_macros.svh
// Assertion macros shared by the delimiter stream splitter RTL.
`ifndef DELIMITER_STREAM_SPLITTER_MACROS_SVH
`define DELIMITER_STREAM_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("delimiter_stream_splitter assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("delimiter_stream_splitter assertion failed");
`else
`define DSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/dss_pkg.sv
// Types and constants shared by the delimiter stream splitter modules.
`default_nettype none
package dss_pkg;

  localparam int DEF_MAX_SEP_LEN = 8;
  localparam int SEP_LEN_W       = 4;
  localparam int SEP_BYTES_W     = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int PART_W          = 16;
  localparam int IN_DATA_W       = 8;
  localparam int IN_USER_W       = 1;
  localparam int OUT_DATA_W      = 24;
  localparam int OUT_USER_W      = 3;

  // Configuration register indexes.
  localparam logic REG_SEP_LEN   = 1'b0;
  localparam logic REG_SEP_BYTES = 1'b1;

  localparam logic [SEP_LEN_W-1:0]   SEP_LEN_RESET   = 4'd1;
  localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RESET = 64'd32;
  localparam logic [PART_W-1:0]      PART_MAX        = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // append the accepted byte to the held bytes
    logic release_b; // emit the oldest held byte as content and drop it
    logic close;     // emit a part end and clear the held bytes
    logic done;      // the part end closes the string
    logic last;      // the emitted result is the last one of its item
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic rel;         // oldest held byte can no longer start a separator
    logic match;       // held bytes form the whole separator
    logic rel_after;   // same as rel, after the oldest byte is dropped
    logic match_after; // same as match, after the oldest byte is dropped
    logic empty;       // nothing is held
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/dss_datapath.sv
// Datapath: configuration, held-byte buffer, prefix compares, part counter, output register.
`default_nettype none
module dss_datapath import dss_pkg::*; #(
  parameter int MAX_SEP_LEN = DEF_MAX_SEP_LEN
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [7:0]             in_byte,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,
  output logic [OUT_USER_W-1:0]       m_tuser,
  output logic                        m_tlast
);

  localparam int CW = $clog2(MAX_SEP_LEN + 1);
  localparam int BW = 8 * MAX_SEP_LEN;

  logic [SEP_LEN_W-1:0]   sep_len;
  logic [SEP_BYTES_W-1:0] sep_bytes;
  logic [BW-1:0]          pend;
  logic [CW-1:0]          count;
  logic [PART_W-1:0]      part;

  logic [SEP_LEN_W-1:0]   len;
  logic [SEP_LEN_W-1:0]   cnt_ext;
  logic [SEP_LEN_W-1:0]   cnt1_ext;
  logic [CW-1:0]          cnt1;
  logic [BW-1:0]          pend_sh;
  logic                   emit;

  // True when the first n held bytes of p equal the first n separator bytes.
  function automatic logic pfx_ok(input logic [BW-1:0] p, input logic [CW-1:0] n,
                                  input logic [SEP_BYTES_W-1:0] s);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      if (CW'(i) < n && p[8*i +: 8] != s[8*i +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  always_comb begin
    if (sep_len == '0) begin
      len = SEP_LEN_W'(1);
    end else if (sep_len > SEP_LEN_W'(MAX_SEP_LEN)) begin
      len = SEP_LEN_W'(MAX_SEP_LEN);
    end else begin
      len = sep_len;
    end
    cnt_ext  = SEP_LEN_W'(count);
    cnt1     = count - CW'(1);
    cnt1_ext = SEP_LEN_W'(cnt1);
    pend_sh  = pend >> 8;
    emit     = cmd.release_b | cmd.close;

    stat.out_free    = ~m_tvalid | m_tready;
    stat.empty       = (count == '0);
    stat.rel         = (count != '0) &&
                       ((cnt_ext > len) || !pfx_ok(pend, count, sep_bytes));
    stat.match       = (cnt_ext == len);
    stat.rel_after   = (cnt1 != '0) &&
                       ((cnt1_ext > len) || !pfx_ok(pend_sh, cnt1, sep_bytes));
    stat.match_after = (cnt1_ext == len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_len   <= SEP_LEN_RESET;
      sep_bytes <= SEP_BYTES_RESET;
      count     <= '0;
      part      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
          REG_SEP_BYTES: sep_bytes <= cfg_data[SEP_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        count <= count + CW'(1);
      end else if (cmd.release_b) begin
        count <= cnt1;
      end else if (cmd.close) begin
        count <= '0;
      end
      if (cmd.close) begin
        if (cmd.done) begin
          part <= '0;
        end else if (part != PART_MAX) begin
          part <= part + PART_W'(1);
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Held bytes and the output payload need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_SEP_LEN; i++) begin
        if (count == CW'(i)) begin
          pend[8*i +: 8] <= in_byte;
        end
      end
    end else if (cmd.release_b) begin
      pend <= pend_sh;
    end
    if (emit) begin
      m_tdata[7:0]  <= cmd.release_b ? pend[7:0] : 8'h00;
      m_tdata[23:8] <= part;
      m_tuser       <= {cmd.close & cmd.done, cmd.close, cmd.release_b};
      m_tlast       <= cmd.last;
    end
  end

endmodule
`default_nettype wire

### hdl/dss_ctrl.sv
// Controller state machine: accepts items and sequences the results of each one.
`default_nettype none
module dss_ctrl import dss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  input  wire logic     s_tuser,
  input  wire logic     s_tlast,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   eos;
  logic   eos_next;

  always_comb begin
    state_next = state;
    eos_next   = eos;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = s_tuser;
          eos_next = s_tlast;
          if (s_tuser) begin
            state_next = ST_SCAN;
          end else if (s_tlast) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        // A result is the last of its item when nothing more follows it.
        priority if (stat.rel) begin
          if (stat.out_free) begin
            cmd.release_b = 1'b1;
            cmd.last      = ~(stat.rel_after | stat.match_after | eos);
          end
        end else if (stat.match) begin
          if (stat.out_free) begin
            cmd.close  = 1'b1;
            cmd.last   = ~eos;
            state_next = eos ? ST_FLUSH : ST_IDLE;
          end
        end else begin
          state_next = eos ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          if (!stat.empty) begin
            cmd.release_b = 1'b1;
          end else begin
            cmd.close  = 1'b1;
            cmd.done   = 1'b1;
            cmd.last   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eos   <= 1'b0;
    end else begin
      state <= state_next;
      eos   <= eos_next;
    end
  end

endmodule
`default_nettype wire

### hdl/delimiter_stream_splitter.sv
// Top level of the delimiter stream splitter: controller, datapath and checks.
// An item is accepted in the idle state; the scan and flush states then issue its results
// into the output register, at most one per cycle and only while the output is not stalled,
// and the register drives them at the output. No new item is taken until the current one is done.
// Synchronous active-high reset clears the state, the held-byte count and the part index.
`default_nettype none
`include "delimiter_stream_splitter_macros.svh"
module delimiter_stream_splitter import dss_pkg::*; #(
  parameter int MAX_SEP_LEN = DEF_MAX_SEP_LEN
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // in_byte
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // in_byte_valid
  input  wire logic                  s_tlast,   // end_of_string
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // out_byte, part_index
  output logic [OUT_USER_W-1:0]      m_tuser,   // out_byte_valid, part_end, string_done
  output logic                       m_tlast    // last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser[0]),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dss_datapath #(
    .MAX_SEP_LEN (MAX_SEP_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A result is either a content byte or a part end, never both.
  `DSS_ASSERT_SAME(a_kind_excl, clk, rst, m_tvalid, m_tuser[0] != m_tuser[1])
  // The string close is a part end and the last result of its item.
  `DSS_ASSERT_SAME(a_done_last, clk, rst, m_tvalid && m_tuser[2], m_tuser[1] && m_tlast)
  // Only one item is in work at a time.
  `DSS_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready && s_tuser[0], !s_tready)
  // The string close is never issued while the datapath holds undelivered bytes.
  `DSS_ASSERT_SAME(a_close_empty, clk, rst, cmd.close && cmd.done, stat.empty)

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the delimiter stream splitter, with a scoreboard class.
module tb;
  import dss_pkg::*;

  localparam int LIMIT_CYCLES      = 500000;
  localparam int SETTLE_CYCLES     = 24;
  localparam int ITEMS_PER_SETTING = 20;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              part_end;
    logic [PART_W-1:0] part_index;
    logic              string_done;
    logic              last_of_run;
  } part_result_t;

  class splitter_scoreboard;
    part_result_t           expected_parts_q[$];
    logic [SEP_LEN_W-1:0]   sep_len;
    logic [SEP_BYTES_W-1:0] sep_bytes;
    logic [7:0]             held[8];
    int                     held_cnt;
    logic [PART_W-1:0]      part;
    int                     errors;
    int                     results_checked;
    int                     parts_closed;
    int                     items_taken;

    function new();
      sep_len = SEP_LEN_RESET;
      sep_bytes = SEP_BYTES_RESET;
      foreach (held[i]) held[i] = 8'h00;
      held_cnt = 0;
      part = '0;
      errors = 0;
      results_checked = 0;
      parts_closed = 0;
      items_taken = 0;
    endfunction

    // Length in use: zero counts as one, anything above the maximum is clipped.
    function int sep_width();
      int l;
      l = sep_len;
      if (l == 0) l = 1;
      if (l > DEF_MAX_SEP_LEN) l = DEF_MAX_SEP_LEN;
      return l;
    endfunction

    function logic [7:0] sep_byte(int i);
      return sep_bytes[i*8 +: 8];
    endfunction

    function void write_reg(logic index, logic [CFG_DATA_W-1:0] value);
      if (index == REG_SEP_LEN) sep_len = value[SEP_LEN_W-1:0];
      else sep_bytes = value;
    endfunction

    function void push_result(logic [7:0] b, logic bv, logic pe, logic done);
      part_result_t r;
      r.out_byte = b;
      r.byte_valid = bv;
      r.part_end = pe;
      r.part_index = part;
      r.string_done = done;
      r.last_of_run = 1'b0;
      expected_parts_q.push_back(r);
    endfunction

    function void release_oldest();
      push_result(held[0], 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 7; i++) held[i] = held[i+1];
      held[7] = 8'h00;
      held_cnt--;
    endfunction

    function bit held_is_sep_prefix();
      for (int i = 0; i < held_cnt; i++)
        if (held[i] != sep_byte(i)) return 1'b0;
      return 1'b1;
    endfunction

    function void close_part(logic done);
      push_result(8'h00, 1'b0, 1'b1, done);
      parts_closed++;
      if (part != PART_MAX) part++;
    endfunction

    // Works out the results of one accepted input transaction.
    function void split_item(logic [7:0] b, logic bv, logic eos);
      int first;
      int len;
      part_result_t r;
      first = expected_parts_q.size();
      len = sep_width();
      items_taken++;
      if (bv) begin
        if (held_cnt >= DEF_MAX_SEP_LEN) release_oldest();
        held[held_cnt] = b;
        held_cnt++;
        while (held_cnt > 0 && (held_cnt > len || !held_is_sep_prefix())) release_oldest();
        if (held_cnt == len) begin
          foreach (held[i]) held[i] = 8'h00;
          held_cnt = 0;
          close_part(1'b0);
        end
      end
      if (eos) begin
        while (held_cnt > 0) release_oldest();
        close_part(1'b1);
        part = '0;
      end
      if (expected_parts_q.size() > first) begin
        r = expected_parts_q.pop_back();
        r.last_of_run = 1'b1;
        expected_parts_q.push_back(r);
      end
    endfunction

    function int pending();
      return expected_parts_q.size();
    endfunction

    function void check_part_result(part_result_t got);
      part_result_t want;
      results_checked++;
      if (expected_parts_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_parts_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.byte_valid !== want.byte_valid) begin
        errors++;
        $display("%0t: out_byte_valid expected %b actual %b", $time, want.byte_valid,
                 got.byte_valid);
      end
      if (got.part_end !== want.part_end) begin
        errors++;
        $display("%0t: part_end expected %b actual %b", $time, want.part_end, got.part_end);
      end
      if (got.part_index !== want.part_index) begin
        errors++;
        $display("%0t: part_index expected %0d actual %0d", $time, want.part_index,
                 got.part_index);
      end
      if (got.string_done !== want.string_done) begin
        errors++;
        $display("%0t: string_done expected %b actual %b", $time, want.string_done,
                 got.string_done);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                 got.last_of_run);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_SEP_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // in_byte
  logic [IN_USER_W-1:0]  s_tuser = '0;   // in_byte_valid
  logic                  s_tlast = 1'b0; // end_of_string
  logic                  m_tready = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;        // out_byte, part_index
  wire [OUT_USER_W-1:0]  m_tuser;        // out_byte_valid, part_end, string_done
  wire                   m_tlast;        // last_of_run

  splitter_scoreboard sb = new();
  bit steady = 1'b0;

  delimiter_stream_splitter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_part_result({m_tdata[7:0], m_tuser[0], m_tuser[1], m_tdata[23:8],
                              m_tuser[2], m_tlast});
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = steady ? 0 : pick_gap();
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic bv, logic eos);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= bv;
    s_tlast <= eos;
    do @(posedge clk); while (!s_tready);
    sb.split_item(b, bv, eos);
  endtask

  // A transaction that holds bytes back gives no result, so allow the block
  // time to finish after the last expected result has come.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_separator(logic [SEP_LEN_W-1:0] len, logic [SEP_BYTES_W-1:0] bytes);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SEP_LEN;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    sb.write_reg(REG_SEP_LEN, CFG_DATA_W'(len));
    cfg_index <= REG_SEP_BYTES;
    cfg_data <= bytes;
    @(posedge clk);
    sb.write_reg(REG_SEP_BYTES, bytes);
    cfg_we <= 1'b0;
  endtask

  // Mostly separators and separator prefixes with random content between them.
  task automatic run_setting(int n);
    int taken;
    int r;
    int k;
    int len;
    logic [7:0] b;
    taken = 0;
    len = sb.sep_width();
    while (taken < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        for (int i = 0; i < len; i++) send_item(sb.sep_byte(i), 1'b1, 1'b0);
        taken += len;
      end else if (r < 50 && len > 1) begin
        k = $urandom_range(1, len - 1);
        for (int i = 0; i < k; i++) send_item(sb.sep_byte(i), 1'b1, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        taken += k + 1;
      end else if (r < 58) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (r < 66) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        taken++;
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 1) == 1) b = sb.sep_byte($urandom_range(0, len - 1));
          else b = 8'($urandom_range(0, 255));
          send_item(b, 1'b1, 1'b0);
        end
        taken += k;
      end
    end
  endtask

  initial begin
    logic [7:0] fill;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset separator is a single space: empty part, zero byte, idle and bare ends.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h20, 1'b1, 1'b1);

    // Zero length acts as one; the separator is a zero byte.
    set_separator(4'd0, 64'h0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    // Oversized length is clipped to eight bytes of all ones.
    set_separator(4'd15, '1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    for (int i = 0; i < DEF_MAX_SEP_LEN; i++) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);

    // Shorten the separator while three bytes are held.
    set_separator(4'd8, 64'h0807060504030201);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    set_separator(4'd2, 64'h0807060504030201);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    set_separator(4'd1, {$urandom, $urandom});
    run_setting(ITEMS_PER_SETTING);
    set_separator(4'd8, {$urandom, $urandom});
    run_setting(ITEMS_PER_SETTING);
    set_separator(4'd0, 64'h0);
    run_setting(ITEMS_PER_SETTING);
    set_separator(4'd15, '1);
    run_setting(ITEMS_PER_SETTING);
    fill = 8'($urandom_range(0, 255));
    set_separator(4'($urandom_range(2, 7)), {8{fill}});
    run_setting(ITEMS_PER_SETTING);
    steady = 1'b1;
    set_separator(4'd3, {$urandom, $urandom});
    run_setting(ITEMS_PER_SETTING);
    steady = 1'b0;
    send_item(8'h00, 1'b0, 1'b1);

    settle();
    $display("Checked %0d results from %0d input transactions, %0d parts closed.",
             sb.results_checked, sb.items_taken, sb.parts_closed);
    $display("Separators of 1 to 8 bytes, clipped lengths, length change mid-string.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### delimiter_stream_splitter.f
+incdir+hdl
hdl/dss_pkg.sv
hdl/dss_datapath.sv
hdl/dss_ctrl.sv
hdl/delimiter_stream_splitter.sv
tb/tb.sv
